// ----- rtl/mahd_pkg.sv -----
// ----------------------------------------------------------------------------
// mahd_pkg
// Shared types, constants and lookup tables for the MPEG audio header decoder.
// ----------------------------------------------------------------------------
package mahd_pkg;

  localparam int NUM_W    = 27;  // numerator of the frame length quotient
  localparam int Q_W      = 12;  // quotient / frame length width
  localparam int RECIP_W  = 26;  // reciprocal constant width
  localparam int RECIP_SH = 40;  // reciprocal scale, 2**RECIP_SH > max numerator
  localparam int PROD_W   = NUM_W + RECIP_W;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_SYNC     = 3'd1,
    ST_RES_VERSION  = 3'd2,
    ST_RES_LAYER    = 3'd3,
    ST_BAD_SAMPLING = 3'd4,
    ST_BAD_BITRATE  = 3'd5
  } status_t;

  localparam logic [1:0] VER_25  = 2'd0;
  localparam logic [1:0] VER_RES = 2'd1;
  localparam logic [1:0] VER_2   = 2'd2;
  localparam logic [1:0] VER_1   = 2'd3;

  localparam logic [1:0] LAYER_RES = 2'd0;
  localparam logic [1:0] LAYER_3   = 2'd1;
  localparam logic [1:0] LAYER_2   = 2'd2;
  localparam logic [1:0] LAYER_1   = 2'd3;

  localparam logic [1:0] SIDX_RES = 2'd3;
  localparam logic [3:0] BIDX_FREE = 4'd0;
  localparam logic [3:0] BIDX_BAD  = 4'd15;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [2:0] SYNC_TAIL = 3'b111;

  localparam logic [18:0] KBPS_TO_BPS = 19'd1000;
  localparam logic [17:0] SLOT_L1     = 18'd12000;   // 12 * 1000
  localparam logic [17:0] SLOT_L23    = 18'd144000;  // 144 * 1000

  localparam logic [8:0] KBPS_M1_L3 [16] = '{
    9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
    9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
  localparam logic [8:0] KBPS_M1_L2 [16] = '{
    9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
    9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
  localparam logic [8:0] KBPS_M1_L1 [16] = '{
    9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
    9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
  localparam logic [8:0] KBPS_LSF_L23 [16] = '{
    9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
    9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};
  localparam logic [8:0] KBPS_LSF_L1 [16] = '{
    9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
    9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  version_code;
    logic [1:0]  layer_code;
    logic [18:0] bitrate_bps;
    logic [15:0] sample_rate_hz;
    logic        padding_flag;
    logic        crc_present;
    logic        private_bit;
    logic [7:0]  new_third_byte;
  } hdr_info_t;

  typedef struct packed {
    hdr_info_t        info;
    logic [NUM_W-1:0] num;
    logic [1:0]       sidx;
  } div_req_t;

  function automatic logic [8:0] kbps_lookup(input logic lsf, input logic [1:0] lay,
                                             input logic [3:0] idx);
    logic [8:0] r;
    r = 9'd0;
    case (lay)
      LAYER_3: r = lsf ? KBPS_LSF_L23[idx] : KBPS_M1_L3[idx];
      LAYER_2: r = lsf ? KBPS_LSF_L23[idx] : KBPS_M1_L2[idx];
      LAYER_1: r = lsf ? KBPS_LSF_L1[idx]  : KBPS_M1_L1[idx];
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // MPEG-1 rate; MPEG-2 halves it, MPEG-2.5 quarters it
  function automatic logic [15:0] base_hz(input logic [1:0] sidx);
    logic [15:0] r;
    case (sidx)
      2'd0:    r = 16'd44100;
      2'd1:    r = 16'd48000;
      2'd2:    r = 16'd32000;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  // floor(2**RECIP_SH / base_hz)
  function automatic logic [RECIP_W-1:0] recip(input logic [1:0] sidx);
    logic [RECIP_W-1:0] r;
    case (sidx)
      2'd0:    r = RECIP_W'(24932236);
      2'd1:    r = RECIP_W'(22906492);
      2'd2:    r = RECIP_W'(34359738);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/mpeg_audio_header_decode_core.sv -----
// ----------------------------------------------------------------------------
// mpeg_audio_header_decode_core
// MPEG audio frame header decoder: sync/version/layer checks, bitrate and
// sampling rate lookup, frame and total length, private bit rewrite.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_ready   header bytes, private bit request
//  out      source     out_valid / out_ready status and decoded header fields
//
//  One word per cycle sustained while out is not stalled; the stages are decode,
//  reciprocal multiply, back-multiply, correction and output register.
//  The whole pipe advances together; a stall on out holds every stage and
//  deasserts in_ready, nothing is dropped or replayed.
//  Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
module mpeg_audio_header_decode_core import mahd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  header_first,
  input  logic [7:0]  header_second,
  input  logic [7:0]  header_third,
  input  logic        write_private,
  input  logic        private_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [1:0]  version_code,
  output logic [1:0]  layer_code,
  output logic [18:0] bitrate_bps,
  output logic [15:0] sample_rate_hz,
  output logic        padding_flag,
  output logic        crc_present,
  output logic [11:0] frame_length,
  output logic [11:0] total_length,
  output logic        private_bit,
  output logic [7:0]  new_third_byte
);

  logic           en;
  logic           req_valid;
  div_req_t       req;
  logic           quo_valid;
  hdr_info_t      quo_info;
  logic [Q_W-1:0] quo;
  logic [Q_W-1:0] slots;
  logic [11:0]    flen_next;
  logic [11:0]    tlen_next;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  mahd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (in_valid),
    .header_first  (header_first),
    .header_second (header_second),
    .header_third  (header_third),
    .write_private (write_private),
    .private_value (private_value),
    .req_valid     (req_valid),
    .req           (req)
  );

  mahd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .req_valid (req_valid),
    .req       (req),
    .quo_valid (quo_valid),
    .quo_info  (quo_info),
    .quo       (quo)
  );

  // Layer I counts 4-byte slots
  always_comb begin
    slots = quo + Q_W'(quo_info.padding_flag);
    if (quo_info.status != ST_OK) begin
      flen_next = '0;
      tlen_next = '0;
    end else begin
      flen_next = (quo_info.layer_code == LAYER_1) ? {slots[9:0], 2'b00} : slots;
      tlen_next = flen_next + 12'd4 + (quo_info.crc_present ? 12'd2 : 12'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= quo_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status         <= quo_info.status;
      version_code   <= quo_info.version_code;
      layer_code     <= quo_info.layer_code;
      bitrate_bps    <= quo_info.bitrate_bps;
      sample_rate_hz <= quo_info.sample_rate_hz;
      padding_flag   <= quo_info.padding_flag;
      crc_present    <= quo_info.crc_present;
      private_bit    <= quo_info.private_bit;
      new_third_byte <= quo_info.new_third_byte;
      frame_length   <= flen_next;
      total_length   <= tlen_next;
    end
  end

endmodule

// ----- rtl/mahd_front.sv -----
// ----------------------------------------------------------------------------
// mahd_front
// Field decode, error checks, table lookups and the length numerator.
// ----------------------------------------------------------------------------
module mahd_front import mahd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  logic [7:0] header_first,
  input  logic [7:0] header_second,
  input  logic [7:0] header_third,
  input  logic       write_private,
  input  logic       private_value,
  output logic       req_valid,
  output div_req_t   req
);

  logic [1:0]       ver, lay, sidx, sh;
  logic [3:0]       bidx;
  logic [8:0]       kbps;
  logic [17:0]      kfac;
  logic [NUM_W+1:0] num_wide;
  status_t          st;
  div_req_t         req_next;

  assign ver  = header_second[4:3];
  assign lay  = header_second[2:1];
  assign bidx = header_third[7:4];
  assign sidx = header_third[3:2];

  always_comb begin
    if (!(header_first == SYNC_BYTE && header_second[7:5] == SYNC_TAIL)) begin
      st = ST_BAD_SYNC;
    end else if (ver == VER_RES) begin
      st = ST_RES_VERSION;
    end else if (lay == LAYER_RES) begin
      st = ST_RES_LAYER;
    end else if (sidx == SIDX_RES) begin
      st = ST_BAD_SAMPLING;
    end else if (bidx == BIDX_FREE || bidx == BIDX_BAD) begin
      st = ST_BAD_BITRATE;
    end else begin
      st = ST_OK;
    end
  end

  always_comb begin
    kbps = kbps_lookup(ver != VER_1, lay, bidx);
    case (ver)
      VER_1:   sh = 2'd0;
      VER_2:   sh = 2'd1;
      default: sh = 2'd2;
    endcase
    kfac     = (lay == LAYER_1) ? SLOT_L1 : SLOT_L23;
    num_wide = ((NUM_W+2)'(kbps) * (NUM_W+2)'(kfac)) << sh;

    req_next = '0;
    req_next.info.status = st;
    if (st == ST_OK) begin
      req_next.info.version_code   = ver;
      req_next.info.layer_code     = lay;
      req_next.info.bitrate_bps    = 19'(kbps) * KBPS_TO_BPS;
      req_next.info.sample_rate_hz = base_hz(sidx) >> sh;
      req_next.info.padding_flag   = header_third[1];
      req_next.info.crc_present    = ~header_second[0];
      req_next.info.private_bit    = header_third[0];
      req_next.info.new_third_byte = write_private ? {header_third[7:1], private_value}
                                                   : header_third;
      req_next.num  = num_wide[NUM_W-1:0];
      req_next.sidx = sidx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (en) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      req <= req_next;
    end
  end

endmodule

// ----- rtl/mahd_div.sv -----
// ----------------------------------------------------------------------------
// mahd_div
// Two-stage division of the numerator by the base sampling rate:
// reciprocal multiply, then back-multiply and a single correction step.
// ----------------------------------------------------------------------------
module mahd_div import mahd_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           req_valid,
  input  div_req_t       req,
  output logic           quo_valid,
  output hdr_info_t      quo_info,
  output logic [Q_W-1:0] quo
);

  logic [PROD_W-1:0] est_wide;
  logic              b_valid;
  div_req_t          b_req;
  logic [Q_W-1:0]    b_q0;

  logic              c_valid;
  div_req_t          c_req;
  logic [Q_W-1:0]    c_q0;
  logic [NUM_W-1:0]  c_prod;

  logic [15:0]       c_div;
  logic [NUM_W-1:0]  rem;

  // estimate is exact or one short
  assign est_wide = PROD_W'(req.num) * PROD_W'(recip(req.sidx));

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (en) begin
      b_valid <= req_valid;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_req  <= req;
      b_q0   <= est_wide[RECIP_SH +: Q_W];
      c_req  <= b_req;
      c_q0   <= b_q0;
      c_prod <= NUM_W'(NUM_W'(b_q0) * NUM_W'(base_hz(b_req.sidx)));
    end
  end

  assign c_div     = base_hz(c_req.sidx);
  assign rem       = c_req.num - c_prod;
  assign quo       = c_q0 + Q_W'(rem >= NUM_W'(c_div));
  assign quo_valid = c_valid;
  assign quo_info  = c_req.info;

endmodule

// ----- rtl/mahd_checker.sv -----
// ----------------------------------------------------------------------------
// mahd_checker
// Port-level checks for the header decoder, bound to the top level.
// ----------------------------------------------------------------------------
module mahd_checker import mahd_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [1:0]  version_code,
  input logic [1:0]  layer_code,
  input logic [18:0] bitrate_bps,
  input logic [15:0] sample_rate_hz,
  input logic        crc_present,
  input logic [11:0] frame_length,
  input logic [11:0] total_length,
  input logic [7:0]  new_third_byte
);

  // a held word keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(frame_length)
      && $stable(bitrate_bps))
    else $error("output word changed while stalled");

  // an error word carries nothing else
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> bitrate_bps == 19'd0 && sample_rate_hz == 16'd0
      && frame_length == 12'd0 && total_length == 12'd0 && new_third_byte == 8'd0
      && version_code == 2'd0 && layer_code == 2'd0)
    else $error("error word with non-zero fields");

  a_total: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |->
      total_length == frame_length + 12'd4 + (crc_present ? 12'd2 : 12'd0))
    else $error("total length mismatch");

  a_layer1_slots: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK && layer_code == LAYER_1 |-> frame_length[1:0] == 2'b00)
    else $error("layer I length not a slot multiple");

  // an empty output register never blocks the input side
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind mpeg_audio_header_decode_core mahd_checker u_mahd_checker (.*);

// ----- test/mpeg_audio_header_decode_core_tb.sv -----
// ----------------------------------------------------------------------------
// mpeg_audio_header_decode_core_tb
// Self-checking bench for the MPEG audio header decoder. Header words go in
// through a bursty valid/ready sender, decoded words come out through a
// receiver that stalls on its own pattern, and every accepted output word is
// compared field by field with a behavioural decode of the same header.
// ----------------------------------------------------------------------------
module mpeg_audio_header_decode_core_tb import mahd_pkg::*; ;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t     status;
    logic [1:0]  version_code;
    logic [1:0]  layer_code;
    logic [18:0] bitrate_bps;
    logic [15:0] sample_rate_hz;
    logic        padding_flag;
    logic        crc_present;
    logic [11:0] frame_length;
    logic [11:0] total_length;
    logic        private_bit;
    logic [7:0]  new_third_byte;
  } hdr_fields_t;

  typedef enum int {
    FLT_SYNC_BYTE,
    FLT_SYNC_TAIL,
    FLT_VERSION,
    FLT_LAYER,
    FLT_SAMPLING,
    FLT_BITRATE
  } fault_t;

  typedef enum int {
    RX_STREAM,
    RX_RANDOM,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_t;

  // kbit/s, indexed by layer code then bitrate index; layer code 0 is reserved
  localparam int M1_KBPS [4][16] = '{
    '{16{0}},
    '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0},
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
    '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0}};
  localparam int LSF_KBPS [4][16] = '{
    '{16{0}},
    '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
    '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0}};
  // Hz, indexed by version code then sampling index
  localparam int RATE_HZ [4][4] = '{
    '{11025, 12000, 8000, 0},
    '{0, 0, 0, 0},
    '{22050, 24000, 16000, 0},
    '{44100, 48000, 32000, 0}};

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  header_first;
  logic [7:0]  header_second;
  logic [7:0]  header_third;
  logic        write_private;
  logic        private_value;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [1:0]  version_code;
  logic [1:0]  layer_code;
  logic [18:0] bitrate_bps;
  logic [15:0] sample_rate_hz;
  logic        padding_flag;
  logic        crc_present;
  logic [11:0] frame_length;
  logic [11:0] total_length;
  logic        private_bit;
  logic [7:0]  new_third_byte;

  hdr_fields_t expected_hdrs[$];
  int          mismatches = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;
  rx_mode_t    rx_mode = RX_STREAM;
  int          rx_left = 0;
  int          rx_phase = 0;

  mpeg_audio_header_decode_core i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .header_first   (header_first),
    .header_second  (header_second),
    .header_third   (header_third),
    .write_private  (write_private),
    .private_value  (private_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .version_code   (version_code),
    .layer_code     (layer_code),
    .bitrate_bps    (bitrate_bps),
    .sample_rate_hz (sample_rate_hz),
    .padding_flag   (padding_flag),
    .crc_present    (crc_present),
    .frame_length   (frame_length),
    .total_length   (total_length),
    .private_bit    (private_bit),
    .new_third_byte (new_third_byte)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic hdr_fields_t decode_header(input logic [7:0] b0, input logic [7:0] b1,
                                                input logic [7:0] b2, input logic wr,
                                                input logic pv);
    hdr_fields_t r;
    logic [1:0]  ver;
    logic [1:0]  lay;
    logic [1:0]  sidx;
    logic [3:0]  bidx;
    int          kbps;
    int          hz;
    int          bps;
    int          flen;
    int          tlen;
    r    = '0;
    ver  = b1[4:3];
    lay  = b1[2:1];
    sidx = b2[3:2];
    bidx = b2[7:4];
    hz   = RATE_HZ[ver][sidx];
    kbps = (ver == VER_1) ? M1_KBPS[lay][bidx] : LSF_KBPS[lay][bidx];
    if (b0 != SYNC_BYTE || b1[7:5] != SYNC_TAIL) begin
      r.status = ST_BAD_SYNC;
    end else if (ver == VER_RES) begin
      r.status = ST_RES_VERSION;
    end else if (lay == LAYER_RES) begin
      r.status = ST_RES_LAYER;
    end else if (hz == 0) begin
      r.status = ST_BAD_SAMPLING;
    end else if (kbps == 0) begin
      r.status = ST_BAD_BITRATE;
    end else begin
      bps = kbps * 1000;
      if (lay == LAYER_1) begin
        flen = (12 * bps / hz + int'(b2[1])) * 4;
      end else begin
        flen = 144 * bps / hz + int'(b2[1]);
      end
      tlen = flen + 4 + (b1[0] ? 0 : 2);
      r.status         = ST_OK;
      r.version_code   = ver;
      r.layer_code     = lay;
      r.bitrate_bps    = 19'(bps);
      r.sample_rate_hz = 16'(hz);
      r.padding_flag   = b2[1];
      r.crc_present    = ~b1[0];
      r.frame_length   = 12'(flen);
      r.total_length   = 12'(tlen);
      r.private_bit    = b2[0];
      r.new_third_byte = wr ? {b2[7:1], pv} : b2;
    end
    return r;
  endfunction

  // Bursty sender: called at a falling edge, returns at the falling edge after
  // the word has been taken. Valid stays high across words within a burst.
  task automatic send_header(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
                             input logic wr, input logic pv);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid      <= 1'b1;
    header_first  <= b0;
    header_second <= b1;
    header_third  <= b2;
    write_private <= wr;
    private_value <= pv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_hdrs.push_back(decode_header(b0, b1, b2, wr, pv));
    burst_left--;
    @(negedge clk);
  endtask

  task automatic build_valid(output logic [7:0] b0, output logic [7:0] b1,
                             output logic [7:0] b2);
    logic [1:0] ver;
    case ($urandom_range(0, 2))
      0:       ver = VER_25;
      1:       ver = VER_2;
      default: ver = VER_1;
    endcase
    b0 = SYNC_BYTE;
    b1 = {SYNC_TAIL, ver, 2'($urandom_range(1, 3)), 1'($urandom)};
    b2 = {4'($urandom_range(1, 14)), 2'($urandom_range(0, 2)), 2'($urandom)};
  endtask

  task automatic wait_for_drain();
    while (expected_hdrs.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed();
    // rates and length extremes across versions and layers
    send_header(SYNC_BYTE, {SYNC_TAIL, VER_1, LAYER_1, 1'b1}, {4'd14, 2'd2, 1'b1, 1'b0},
                1'b0, 1'b0);
    send_header(SYNC_BYTE, {SYNC_TAIL, VER_1, LAYER_3, 1'b1}, {4'd9, 2'd0, 1'b1, 1'b0},
                1'b1, 1'b1);
    send_header(SYNC_BYTE, {SYNC_TAIL, VER_1, LAYER_2, 1'b0}, {4'd14, 2'd1, 1'b0, 1'b1},
                1'b1, 1'b0);
    send_header(SYNC_BYTE, {SYNC_TAIL, VER_2, LAYER_3, 1'b1}, {4'd1, 2'd0, 1'b0, 1'b0},
                1'b0, 1'b1);
    send_header(SYNC_BYTE, {SYNC_TAIL, VER_25, LAYER_2, 1'b0}, {4'd14, 2'd2, 1'b1, 1'b1},
                1'b0, 1'b0);
    send_header(SYNC_BYTE, {SYNC_TAIL, VER_25, LAYER_1, 1'b1}, {4'd14, 2'd2, 1'b1, 1'b0},
                1'b1, 1'b1);
    send_header(SYNC_BYTE, {SYNC_TAIL, VER_1, LAYER_1, 1'b1}, {4'd1, 2'd0, 1'b0, 1'b0},
                1'b0, 1'b0);
    send_header(SYNC_BYTE, {SYNC_TAIL, VER_2, LAYER_1, 1'b0}, {4'd14, 2'd1, 1'b0, 1'b1},
                1'b1, 1'b0);
    send_header(SYNC_BYTE, {SYNC_TAIL, VER_25, LAYER_3, 1'b0}, {4'd8, 2'd1, 1'b0, 1'b1},
                1'b0, 1'b0);
    send_header(SYNC_BYTE, {SYNC_TAIL, VER_2, LAYER_2, 1'b1}, {4'd7, 2'd2, 1'b1, 1'b0},
                1'b1, 1'b1);
    // sync failures, then each later check with the next one also failing
    send_header(8'hFE, {SYNC_TAIL, VER_1, LAYER_3, 1'b1}, {4'd9, 2'd0, 1'b0, 1'b1},
                1'b1, 1'b1);
    send_header(SYNC_BYTE, {3'b110, VER_1, LAYER_3, 1'b1}, {4'd9, 2'd0, 1'b0, 1'b1},
                1'b0, 1'b0);
    send_header(8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    send_header(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1);
    send_header(SYNC_BYTE, {SYNC_TAIL, VER_RES, LAYER_RES, 1'b1}, {BIDX_FREE, SIDX_RES, 2'b11},
                1'b1, 1'b0);
    send_header(SYNC_BYTE, {SYNC_TAIL, VER_1, LAYER_RES, 1'b0}, {BIDX_BAD, SIDX_RES, 2'b01},
                1'b0, 1'b0);
    send_header(SYNC_BYTE, {SYNC_TAIL, VER_2, LAYER_2, 1'b1}, {BIDX_FREE, SIDX_RES, 2'b10},
                1'b0, 1'b1);
    send_header(SYNC_BYTE, {SYNC_TAIL, VER_1, LAYER_3, 1'b1}, {BIDX_FREE, 2'd0, 2'b11},
                1'b1, 1'b0);
    send_header(SYNC_BYTE, {SYNC_TAIL, VER_25, LAYER_1, 1'b0}, {BIDX_BAD, 2'd2, 2'b01},
                1'b1, 1'b1);
    send_header(SYNC_BYTE, {SYNC_TAIL, VER_RES, LAYER_3, 1'b1}, {4'd5, 2'd1, 2'b00},
                1'b0, 1'b0);
  endtask

  task automatic test_random_valid(input int count);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    for (int i = 0; i < count; i++) begin
      gaps_on = (i >= count / 3);
      build_valid(b0, b1, b2);
      send_header(b0, b1, b2, 1'($urandom), 1'($urandom));
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_broken(input int count);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    fault_t     flt;
    for (int i = 0; i < count; i++) begin
      build_valid(b0, b1, b2);
      flt = fault_t'($urandom_range(0, 5));
      case (flt)
        FLT_SYNC_BYTE: b0 = 8'($urandom_range(0, 254));
        FLT_SYNC_TAIL: b1[7:5] = 3'($urandom_range(0, 6));
        FLT_VERSION:   b1[4:3] = VER_RES;
        FLT_LAYER:     b1[2:1] = LAYER_RES;
        FLT_SAMPLING:  b2[3:2] = SIDX_RES;
        default:       b2[7:4] = $urandom_range(0, 1) ? BIDX_FREE : BIDX_BAD;
      endcase
      send_header(b0, b1, b2, 1'($urandom), 1'($urandom));
    end
  endtask

  task automatic test_noise(input int count);
    for (int i = 0; i < count; i++) begin
      send_header(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  // sender holds off until the pipe is empty, then restarts
  task automatic test_drain_pause();
    test_random_valid(20);
    in_valid <= 1'b0;
    wait_for_drain();
    burst_left = 0;
    test_random_valid(20);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    hdr_fields_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_hdrs.size() == 0) begin
        $error("output word with nothing outstanding");
        mismatches++;
      end else begin
        want = expected_hdrs.pop_front();
        check_field("status", 32'(want.status), 32'(status));
        check_field("version_code", 32'(want.version_code), 32'(version_code));
        check_field("layer_code", 32'(want.layer_code), 32'(layer_code));
        check_field("bitrate_bps", 32'(want.bitrate_bps), 32'(bitrate_bps));
        check_field("sample_rate_hz", 32'(want.sample_rate_hz), 32'(sample_rate_hz));
        check_field("padding_flag", 32'(want.padding_flag), 32'(padding_flag));
        check_field("crc_present", 32'(want.crc_present), 32'(crc_present));
        check_field("frame_length", 32'(want.frame_length), 32'(frame_length));
        check_field("total_length", 32'(want.total_length), 32'(total_length));
        check_field("private_bit", 32'(want.private_bit), 32'(private_bit));
        check_field("new_third_byte", 32'(want.new_third_byte), 32'(new_third_byte));
      end
    end
  end

  // receiver back-pressure: switches between a few stall patterns
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 120);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_phase <= rx_phase + 1;
    case (rx_mode)
      RX_STREAM:   out_ready <= 1'b1;
      RX_RANDOM:   out_ready <= 1'($urandom);
      RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
      default:     out_ready <= (rx_phase % 3 != 0);
    endcase
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    header_first  = '0;
    header_second = '0;
    header_third  = '0;
    write_private = 1'b0;
    private_value = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_random_valid(1000);
    test_broken(250);
    test_noise(250);
    test_drain_pause();
    in_valid <= 1'b0;

    wait_for_drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_hdrs.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
